// ===== design/ffs3_pkg.sv =====
// Shared types, constants and helpers of the 3x3 firefly suppression block.
package ffs3_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 2048;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    localparam int CH_W   = 16;            // Q8.8 channel
    localparam int PIX_W  = 4 * CH_W;      // red, green, blue, alpha
    localparam int LUMA_W = 2 * CH_W;      // Q8.24 luminance
    localparam int THR_W  = LUMA_W + 3;    // 4 * max + half
    localparam int FW_W   = 12;            // frame_width register
    localparam int FH_W   = 13;            // frame_height register
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [FW_W-1:0] RESET_WIDTH  = 12'd1024;
    localparam logic [FH_W-1:0] RESET_HEIGHT = 13'd1024;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Rec.709 weights, Q0.16
    localparam logic [CH_W-1:0] W_RED   = 16'd13933;
    localparam logic [CH_W-1:0] W_GREEN = 16'd46871;
    localparam logic [CH_W-1:0] W_BLUE  = 16'd4732;

    localparam logic [THR_W-1:0] THR_HALF = THR_W'(1) << 23;

    typedef logic [1:0] t_bank;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        t_bank      rd_bank;
        logic       mac_en;
        logic       mac_clr;
        logic [1:0] mac_ch;
        logic       px_nb;
        logic       max_clr;
        logic       px_ctr;
        logic       div_load;
        logic       div_step;
        logic       div_last;
        logic [1:0] div_ch;
        logic       wr_en;
        t_bank      wr_bank;
        logic       wr_from_in;
        logic       out_load;
        logic       out_last;
        logic       enable;
    } t_cmd;

    typedef struct packed {
        logic sup;
        logic out_free;
    } t_status;

    function automatic logic [CH_W-1:0] luma_weight(input logic [1:0] ch);
        logic [CH_W-1:0] w;
        case (ch)
            CH_RED:   w = W_RED;
            CH_GREEN: w = W_GREEN;
            CH_BLUE:  w = W_BLUE;
            default:  w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== design/firefly_suppression_3x3_unit.sv =====
// Streaming 3x3-neighborhood firefly suppressor on Q8.8 RGBA pixels in raster order; each
// transaction is taken one at a time. A transaction that releases a pixel makes nine reads,
// one at a time, from the line buffers, each followed by a luminance multiply-accumulate over
// red, green and blue; a suppressed pixel then goes through the bit-serial scaler, one
// channel after another. Results trail the input by one row plus one pixel; drain
// transactions flush the tail. An accepted transaction does not wait for the output register
// to be taken unless it needs it. Configuration writes are meant for idle periods only.
module firefly_suppression_3x3_unit #(
    parameter int MAX_WIDTH  = ffs3_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = ffs3_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_drain,
    input  logic                           i_start_of_frame,
    input  logic [15:0]                    i_red_in,
    input  logic [15:0]                    i_green_in,
    input  logic [15:0]                    i_blue_in,
    input  logic [15:0]                    i_alpha_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [15:0]                    o_red_out,
    output logic [15:0]                    o_green_out,
    output logic [15:0]                    o_blue_out,
    output logic [15:0]                    o_alpha_out,
    output logic                           o_was_suppressed,
    output logic                           o_frame_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffs3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffs3_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ffs3_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    t_cmd          w_cmd;
    t_status       w_status;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;

    ffs3_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_drain          (i_drain),
        .i_start_of_frame (i_start_of_frame),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_status         (w_status),
        .o_cmd            (w_cmd),
        .o_rd_addr        (w_rd_addr),
        .o_wr_addr        (w_wr_addr)
    );

    ffs3_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_rd_addr        (w_rd_addr),
        .i_wr_addr        (w_wr_addr),
        .i_red_in         (i_red_in),
        .i_green_in       (i_green_in),
        .i_blue_in        (i_blue_in),
        .i_alpha_in       (i_alpha_in),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_red_out        (o_red_out),
        .o_green_out      (o_green_out),
        .o_blue_out       (o_blue_out),
        .o_alpha_out      (o_alpha_out),
        .o_was_suppressed (o_was_suppressed),
        .o_frame_last     (o_frame_last)
    );

endmodule

// ===== design/ffs3_dp.sv =====
// Datapath: three line buffers, luminance MAC, threshold, bit-serial scaler, output register.
module ffs3_dp #(
    parameter int MAX_WIDTH = ffs3_pkg::DEFAULT_MAX_WIDTH,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffs3_pkg::t_cmd        i_cmd,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [15:0]           i_red_in,
    input  logic [15:0]           i_green_in,
    input  logic [15:0]           i_blue_in,
    input  logic [15:0]           i_alpha_in,
    output ffs3_pkg::t_status     o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [15:0]           o_red_out,
    output logic [15:0]           o_green_out,
    output logic [15:0]           o_blue_out,
    output logic [15:0]           o_alpha_out,
    output logic                  o_was_suppressed,
    output logic                  o_frame_last
);
    import ffs3_pkg::*;

    logic [PIX_W-1:0]  r_in_px;
    logic [PIX_W-1:0]  r_bank_q [3];
    t_bank             r_rd_bank;
    logic [PIX_W-1:0]  w_rd_data;
    logic [PIX_W-1:0]  w_wr_data;
    logic [CH_W-1:0]   w_mac_ch;
    logic [LUMA_W-1:0] w_prod;
    logic [LUMA_W-1:0] r_acc;
    logic [LUMA_W-1:0] r_max;
    logic [LUMA_W-1:0] r_lum;
    logic [PIX_W-1:0]  r_px;
    logic [THR_W-1:0]  w_thr;
    logic              w_sup;
    logic [LUMA_W-1:0] r_rem;
    logic [CH_W-1:0]   r_q;
    logic [CH_W-1:0]   r_c;
    logic [LUMA_W+1:0] w_rr;
    logic [LUMA_W+1:0] w_d1;
    logic [LUMA_W+1:0] w_d2;
    logic [LUMA_W+1:0] w_rr_next;
    logic [1:0]        w_digit;
    logic [CH_W:0]     w_q_next;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_px;
    logic              r_out_sup;
    logic              r_out_last;
    logic              w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_px <= {i_alpha_in, i_blue_in, i_green_in, i_red_in};
        end
    end

    assign w_wr_data = i_cmd.wr_from_in ? r_in_px : r_px;

    // line buffer banks; roles rotate in the controller
    for (genvar b = 0; b < 3; b++) begin : g_bank
        logic [PIX_W-1:0] r_mem [MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (i_cmd.wr_en && i_cmd.wr_bank == 2'(b)) begin
                r_mem[i_wr_addr] <= w_wr_data;
            end
            if (i_cmd.rd_en && i_cmd.rd_bank == 2'(b)) begin
                r_bank_q[b] <= r_mem[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_bank <= i_cmd.rd_bank;
        end
    end

    always_comb begin
        case (r_rd_bank)
            2'd0:    w_rd_data = r_bank_q[0];
            2'd1:    w_rd_data = r_bank_q[1];
            default: w_rd_data = r_bank_q[2];
        endcase
    end

    // one channel * weight per cycle while mac_en is set
    assign w_mac_ch = w_rd_data[CH_W*i_cmd.mac_ch +: CH_W];
    assign w_prod   = {{CH_W{1'b0}}, w_mac_ch} * {{CH_W{1'b0}}, luma_weight(i_cmd.mac_ch)};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_en) begin
            r_acc <= (i_cmd.mac_clr ? '0 : r_acc) + w_prod;
        end
        if (i_cmd.px_nb && (i_cmd.max_clr || r_acc > r_max)) begin
            r_max <= r_acc;
        end
        if (i_cmd.px_ctr) begin
            r_lum <= r_acc;
        end
    end

    assign w_thr = {1'b0, r_max, 2'b00} + THR_HALF;
    assign w_sup = i_cmd.enable && ({3'b000, r_lum} > w_thr);

    // floor(c * thr / lum): one bit of c per step, remainder stays below lum
    assign w_rr = {1'b0, r_rem, 1'b0} + (r_c[CH_W-1] ? {2'b00, w_thr[LUMA_W-1:0]} : '0);
    assign w_d1 = {2'b00, r_lum};
    assign w_d2 = {1'b0, r_lum, 1'b0};

    always_comb begin
        if (w_rr >= w_d2) begin
            w_rr_next = w_rr - w_d2;
            w_digit   = 2'd2;
        end else if (w_rr >= w_d1) begin
            w_rr_next = w_rr - w_d1;
            w_digit   = 2'd1;
        end else begin
            w_rr_next = w_rr;
            w_digit   = 2'd0;
        end
    end

    assign w_q_next = {r_q, 1'b0} + {{(CH_W-1){1'b0}}, w_digit};

    always_ff @(posedge i_clk) begin
        if (i_cmd.px_ctr) begin
            r_px <= w_rd_data;
        end else if (i_cmd.div_step && i_cmd.div_last) begin
            r_px[CH_W*i_cmd.div_ch +: CH_W] <= w_q_next[CH_W-1:0];
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_q   <= '0;
            r_c   <= r_px[CH_W*i_cmd.div_ch +: CH_W];
        end else if (i_cmd.div_step) begin
            r_rem <= w_rr_next[LUMA_W-1:0];
            r_q   <= w_q_next[CH_W-1:0];
            r_c   <= {r_c[CH_W-2:0], 1'b0};
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_px   <= r_px;
            r_out_sup  <= w_sup;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_status.sup      = w_sup;
    assign o_status.out_free = w_out_free;

    assign o_out_valid      = r_out_valid;
    assign o_red_out        = r_out_px[0*CH_W +: CH_W];
    assign o_green_out      = r_out_px[1*CH_W +: CH_W];
    assign o_blue_out       = r_out_px[2*CH_W +: CH_W];
    assign o_alpha_out      = r_out_px[3*CH_W +: CH_W];
    assign o_was_suppressed = r_out_sup;
    assign o_frame_last     = r_out_last;

endmodule

// ===== design/ffs3_ctrl.sv =====
// Controller: config registers, raster counters, line buffer roles and the sequencing FSM.
module ffs3_ctrl #(
    parameter int MAX_WIDTH  = ffs3_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = ffs3_pkg::DEFAULT_MAX_HEIGHT,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_drain,
    input  logic                           i_start_of_frame,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffs3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffs3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  ffs3_pkg::t_status              i_status,
    output ffs3_pkg::t_cmd                 o_cmd,
    output logic [AW-1:0]                  o_rd_addr,
    output logic [AW-1:0]                  o_wr_addr
);
    import ffs3_pkg::*;

    localparam int XW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
    localparam int YW = ($clog2(MAX_HEIGHT + 1) > FH_W) ? $clog2(MAX_HEIGHT + 1) : FH_W;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_STORE = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_M0    = 4'd4;
    localparam logic [3:0] S_M1    = 4'd5;
    localparam logic [3:0] S_M2    = 4'd6;
    localparam logic [3:0] S_PX    = 4'd7;
    localparam logic [3:0] S_DEC   = 4'd8;
    localparam logic [3:0] S_DINIT = 4'd9;
    localparam logic [3:0] S_DSTEP = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    localparam logic [3:0] K_CENTER = 4'd8;
    localparam logic [3:0] DIV_LAST = 4'(CH_W - 1);

    logic [3:0]      r_state, n_state;
    logic            r_en;
    logic [FW_W-1:0] r_fw;
    logic [FH_W-1:0] r_fh;
    logic [AW-1:0]   r_in_col, r_out_col;
    logic [RW-1:0]   r_in_row, r_out_row;
    logic            r_in_done, r_out_done;
    t_bank           r_cur;
    logic            r_drain, r_emitted, r_stored;
    logic [3:0]      r_k;
    logic [3:0]      r_dcnt;
    logic [1:0]      r_dch;

    logic [XW-1:0] w_w, w_oc1, w_ic1, w_rx;
    logic [YW-1:0] w_h, w_or1, w_ir1, w_ry, w_in_row;
    logic          w_out_ready;
    logic [AW-1:0] w_xl, w_xr;
    t_bank         w_b_prev, w_b_next, w_b_up, w_b_dn;
    logic          w_st_cur, w_st_next, w_st_do;
    logic          w_accept;

    always_comb begin
        if (r_fw == '0) begin
            w_w = XW'(1);
        end else if (XW'(r_fw) > XW'(MAX_WIDTH)) begin
            w_w = XW'(MAX_WIDTH);
        end else begin
            w_w = XW'(r_fw);
        end
        if (r_fh == '0) begin
            w_h = YW'(1);
        end else if (YW'(r_fh) > YW'(MAX_HEIGHT)) begin
            w_h = YW'(MAX_HEIGHT);
        end else begin
            w_h = YW'(r_fh);
        end
    end

    assign w_oc1    = XW'(r_out_col) + XW'(1);
    assign w_ic1    = XW'(r_in_col) + XW'(1);
    assign w_or1    = YW'(r_out_row) + YW'(1);
    assign w_ir1    = YW'(r_in_row) + YW'(1);
    assign w_in_row = YW'(r_in_row);
    assign w_rx     = (w_oc1 < w_w) ? w_oc1 : w_w - XW'(1);
    assign w_ry     = (w_or1 < w_h) ? w_or1 : w_h - YW'(1);

    // lower-right neighbor must have arrived
    assign w_out_ready = !r_out_done && (r_in_done || w_in_row > w_ry ||
                         (w_in_row == w_ry && XW'(r_in_col) > w_rx));

    assign w_xl = (r_out_col == '0) ? '0 : r_out_col - AW'(1);
    assign w_xr = (w_oc1 < w_w) ? AW'(w_oc1) : AW'(w_w - XW'(1));

    assign w_b_prev = (r_cur == 2'd0) ? 2'd2 : r_cur - 2'd1;
    assign w_b_next = (r_cur == 2'd2) ? 2'd0 : r_cur + 2'd1;
    assign w_b_up   = (r_out_row != '0) ? w_b_prev : r_cur;
    assign w_b_dn   = (w_or1 < w_h) ? w_b_next : r_cur;

    assign w_st_cur  = (w_in_row == YW'(r_out_row));
    assign w_st_next = (w_in_row == w_or1) && !r_out_done;
    assign w_st_do   = !r_drain && !r_in_done && (w_st_cur || w_st_next);

    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_cfg_ready = i_rst_n;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.enable  = r_en;
        o_cmd.capture = w_accept;
        o_cmd.mac_ch  = CH_RED;
        o_cmd.div_ch  = r_dch;
        o_rd_addr     = r_out_col;
        o_wr_addr     = r_out_col;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CHK;
            end
            S_CHK: begin
                if (!r_emitted && w_out_ready) n_state = S_RD;
                else if (!r_stored)            n_state = S_STORE;
                else                           n_state = S_IDLE;
            end
            S_STORE: begin
                o_cmd.wr_en      = w_st_do;
                o_cmd.wr_bank    = w_st_cur ? r_cur : w_b_next;
                o_cmd.wr_from_in = 1'b1;
                o_wr_addr        = r_in_col;
                n_state          = S_CHK;
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                case (r_k)
                    4'd0:    begin o_cmd.rd_bank = w_b_up;   o_rd_addr = w_xl;      end
                    4'd1:    begin o_cmd.rd_bank = w_b_up;   o_rd_addr = r_out_col; end
                    4'd2:    begin o_cmd.rd_bank = w_b_up;   o_rd_addr = w_xr;      end
                    4'd3:    begin o_cmd.rd_bank = r_cur;    o_rd_addr = w_xl;      end
                    4'd4:    begin o_cmd.rd_bank = r_cur;    o_rd_addr = w_xr;      end
                    4'd5:    begin o_cmd.rd_bank = w_b_dn;   o_rd_addr = w_xl;      end
                    4'd6:    begin o_cmd.rd_bank = w_b_dn;   o_rd_addr = r_out_col; end
                    4'd7:    begin o_cmd.rd_bank = w_b_dn;   o_rd_addr = w_xr;      end
                    default: begin o_cmd.rd_bank = r_cur;    o_rd_addr = r_out_col; end
                endcase
                n_state = S_M0;
            end
            S_M0: begin
                o_cmd.mac_en  = 1'b1;
                o_cmd.mac_clr = 1'b1;
                o_cmd.mac_ch  = CH_RED;
                n_state       = S_M1;
            end
            S_M1: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.mac_ch = CH_GREEN;
                n_state      = S_M2;
            end
            S_M2: begin
                o_cmd.mac_en = 1'b1;
                o_cmd.mac_ch = CH_BLUE;
                n_state      = S_PX;
            end
            S_PX: begin
                if (r_k == K_CENTER) begin
                    o_cmd.px_ctr = 1'b1;
                    n_state      = S_DEC;
                end else begin
                    o_cmd.px_nb   = 1'b1;
                    o_cmd.max_clr = (r_k == 4'd0);
                    n_state       = S_RD;
                end
            end
            S_DEC: begin
                n_state = i_status.sup ? S_DINIT : S_OUT;
            end
            S_DINIT: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_last = (r_dcnt == DIV_LAST);
                if (r_dcnt == DIV_LAST) begin
                    n_state = (r_dch == CH_BLUE) ? S_OUT : S_DINIT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.wr_en    = i_status.sup;
                    o_cmd.wr_bank  = r_cur;
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (w_oc1 >= w_w) && (w_or1 >= w_h);
                    n_state        = S_CHK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
            r_fw <= RESET_WIDTH;
            r_fh <= RESET_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE: r_en <= i_cfg_data[0];
                CFG_WIDTH:  r_fw <= i_cfg_data[FW_W-1:0];
                CFG_HEIGHT: r_fh <= i_cfg_data[FH_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_in_done  <= 1'b0;
            r_out_done <= 1'b0;
            r_cur      <= 2'd0;
            r_drain    <= 1'b0;
            r_emitted  <= 1'b0;
            r_stored   <= 1'b0;
            r_k        <= '0;
            r_dcnt     <= '0;
            r_dch      <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_drain   <= i_drain;
                        r_emitted <= 1'b0;
                        r_stored  <= 1'b0;
                        r_k       <= '0;
                        // start of frame restarts the raster counters and done flags; ignored on drains
                        if (!i_drain && i_start_of_frame) begin
                            r_in_col   <= '0;
                            r_in_row   <= '0;
                            r_out_col  <= '0;
                            r_out_row  <= '0;
                            r_in_done  <= 1'b0;
                            r_out_done <= 1'b0;
                        end
                    end
                end
                S_STORE: begin
                    r_stored <= 1'b1;
                    if (w_st_do) begin
                        if (w_ic1 >= w_w) begin
                            r_in_col <= '0;
                            if (w_ir1 >= w_h) r_in_done <= 1'b1;
                            else              r_in_row  <= r_in_row + RW'(1);
                        end else begin
                            r_in_col <= r_in_col + AW'(1);
                        end
                    end
                end
                S_PX: begin
                    if (r_k != K_CENTER) r_k <= r_k + 4'd1;
                end
                S_DEC: begin
                    r_k   <= '0;
                    r_dch <= CH_RED;
                end
                S_DINIT: begin
                    r_dcnt <= '0;
                end
                S_DSTEP: begin
                    r_dcnt <= r_dcnt + 4'd1;
                    if (r_dcnt == DIV_LAST) r_dch <= r_dch + 2'd1;
                end
                S_OUT: begin
                    if (i_status.out_free) begin
                        r_emitted <= 1'b1;
                        if (w_oc1 >= w_w) begin
                            r_out_col <= '0;
                            if (w_or1 >= w_h) begin
                                r_out_done <= 1'b1;
                            end else begin
                                // current becomes processed, incoming becomes current
                                r_out_row <= r_out_row + RW'(1);
                                r_cur     <= w_b_next;
                            end
                        end else begin
                            r_out_col <= r_out_col + AW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
